FILE: rtl/wrsi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wrsi_pkg: shared types and constants of the Wilder RSI core
// Fixed widths, codes and the command and status structures that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package wrsi_pkg;

	localparam int PRICE_W   = 32;
	localparam int PERIOD_W  = 8;
	localparam int FRAC_BITS = 16;
	localparam int PERIOD_MAX = 255;

	// Change counter saturates at PERIOD_MAX + 1.
	localparam int CHG_W = $clog2(PERIOD_MAX + 2);
	localparam logic [CHG_W-1:0] CHG_SAT = CHG_W'(PERIOD_MAX + 1);

	// Averages are Q32.FRAC_BITS; raw sums before the seed fit in the same word.
	localparam int AVG_W = PRICE_W + FRAC_BITS;
	// Seed dividend: a raw sum of up to PERIOD_MAX changes, shifted by FRAC_BITS.
	localparam int SUM_W = PRICE_W + $clog2(PERIOD_MAX + 1);
	localparam int DIV_W = SUM_W + FRAC_BITS;

	localparam int RSI_W = 23;
	localparam logic [RSI_W-1:0] RSI_FULL = RSI_W'(100 << FRAC_BITS);

	// Ratio unit: divisor is G+L, partial remainder stays below three divisors.
	localparam int S_W = AVG_W + 1;
	localparam int R_W = AVG_W + 3;

	localparam int CNT_W = $clog2(DIV_W);
	localparam int RB_W  = $clog2(RSI_W);

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(14);

	localparam int LANE_GAIN = 0;
	localparam int LANE_LOSS = 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SETUP,
		ST_DIVIDE,
		ST_UPDATE,
		ST_RATIO_INIT,
		ST_RATIO,
		ST_OUTPUT
	} wrsi_state_t;

	typedef enum logic [1:0] {
		PH_SHIFT,
		PH_SUB_A,
		PH_SUB_B
	} wrsi_phase_t;

	typedef struct packed {
		logic            load;
		logic            diff;
		logic            setup;
		logic            div_step;
		logic            update;
		logic            ratio_init;
		logic            ratio_shift;
		logic            ratio_sub;
		logic [RB_W-1:0] ratio_bit;
		logic            out_load;
	} wrsi_cmd_t;

	typedef struct packed {
		logic has_change;
		logic accumulate;
		logic loss_zero;
	} wrsi_status_t;

endpackage
`default_nettype wire

FILE: rtl/wrsi_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wrsi_if: channel interfaces of the Wilder RSI core
// Price input channel, result output channel and period write channel,
// each with valid/ready flow control.
// ----------------------------------------------------------------------------
interface wrsi_price_if;
	logic                          valid;
	logic                          ready;
	logic [wrsi_pkg::PRICE_W-1:0]  close_price;
	logic                          new_series;

	modport source (output valid, output close_price, output new_series, input ready);
	modport sink   (input valid, input close_price, input new_series, output ready);
endinterface

interface wrsi_result_if;
	logic                        valid;
	logic                        ready;
	logic                        rsi_valid;
	logic [wrsi_pkg::RSI_W-1:0]  rsi_value;

	modport source (output valid, output rsi_valid, output rsi_value, input ready);
	modport sink   (input valid, input rsi_valid, input rsi_value, output ready);
endinterface

interface wrsi_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [wrsi_pkg::PERIOD_W-1:0]  period;

	modport source (output valid, output period, input ready);
	modport sink   (input valid, input period, output ready);
endinterface
`default_nettype wire

FILE: rtl/wrsi_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wrsi_ctrl: sequencer of the Wilder RSI core
// Steps one price through difference, division, smoothing and ratio
// phases and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module wrsi_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	input  wire wrsi_pkg::wrsi_status_t status,
	output wrsi_pkg::wrsi_cmd_t         cmd
);
	import wrsi_pkg::*;

	wrsi_state_t           state_q, state_d;
	wrsi_phase_t           phase_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  out_valid_q;
	logic                  can_load;

	assign can_load  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DIFF;
			end
			ST_DIFF: state_d = ST_SETUP;
			ST_SETUP: begin
				if (!status.has_change || status.accumulate) state_d = ST_OUTPUT;
				else state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (cnt_q == CNT_W'(DIV_W - 1)) state_d = ST_UPDATE;
			end
			ST_UPDATE: state_d = ST_RATIO_INIT;
			ST_RATIO_INIT: begin
				if (status.loss_zero) state_d = ST_OUTPUT;
				else state_d = ST_RATIO;
			end
			ST_RATIO: begin
				if (phase_q == PH_SUB_B && cnt_q == '0) state_d = ST_OUTPUT;
			end
			ST_OUTPUT: begin
				if (can_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd             = '0;
		cmd.ratio_bit   = cnt_q[RB_W-1:0];
		in_ready        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DIFF:       cmd.diff = 1'b1;
			ST_SETUP:      cmd.setup = 1'b1;
			ST_DIVIDE:     cmd.div_step = 1'b1;
			ST_UPDATE:     cmd.update = 1'b1;
			ST_RATIO_INIT: cmd.ratio_init = 1'b1;
			ST_RATIO: begin
				cmd.ratio_shift = (phase_q == PH_SHIFT);
				cmd.ratio_sub   = (phase_q != PH_SHIFT);
			end
			ST_OUTPUT:     cmd.out_load = can_load;
			default:       cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_SHIFT;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			case (state_q)
				ST_SETUP:  cnt_q <= '0;
				ST_DIVIDE: cnt_q <= cnt_q + CNT_W'(1);
				ST_RATIO_INIT: begin
					cnt_q   <= CNT_W'(RSI_W - 1);
					phase_q <= PH_SHIFT;
				end
				ST_RATIO: begin
					case (phase_q)
						PH_SHIFT: phase_q <= PH_SUB_A;
						PH_SUB_A: phase_q <= PH_SUB_B;
						PH_SUB_B: begin
							phase_q <= PH_SHIFT;
							cnt_q   <= cnt_q - CNT_W'(1);
						end
						default: phase_q <= PH_SHIFT;
					endcase
				end
				default: cnt_q <= cnt_q;
			endcase

			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/wrsi_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wrsi_dp: datapath of the Wilder RSI core
// Series state, two bit-serial dividers by the period (gain and loss lanes),
// the shift-and-subtract ratio unit and the result register.
// ----------------------------------------------------------------------------
module wrsi_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire wrsi_pkg::wrsi_cmd_t         cmd,
	output wrsi_pkg::wrsi_status_t           status,
	input  wire logic                        cfg_write,
	input  wire logic [wrsi_pkg::PERIOD_W-1:0] cfg_period,
	input  wire logic [wrsi_pkg::PRICE_W-1:0]  close_price,
	input  wire logic                        new_series,
	output logic                             rsi_valid,
	output logic [wrsi_pkg::RSI_W-1:0]       rsi_value
);
	import wrsi_pkg::*;

	// Series state.
	logic [PERIOD_W-1:0] period_q;
	logic [PRICE_W-1:0]  last_close_q;
	logic                close_valid_q;
	logic [CHG_W-1:0]    changes_q;
	logic [AVG_W-1:0]    avg_q [2];

	// Per-item working registers.
	logic [PRICE_W-1:0]  price_q;
	logic [PRICE_W-1:0]  diff_q [2];
	logic                chg_q;
	logic                seed_q;
	logic                val_q;
	logic [DIV_W-1:0]    num_q [2];
	logic [PERIOD_W-1:0] rem_q [2];
	logic                sub_q [2];
	logic [S_W-1:0]      sum_q;
	logic [R_W-1:0]      r_q;
	logic [RSI_W-1:0]    rsi_q;
	logic                res_valid_q;
	logic [RSI_W-1:0]    res_value_q;

	logic [PERIOD_W-1:0] p_eff;
	logic [CHG_W-1:0]    p_chg;
	logic                accumulate;
	logic                seed;
	logic [AVG_W-1:0]    x_w       [2];
	logic [DIV_W-1:0]    setup_num [2];
	logic                setup_sub [2];
	logic [PERIOD_W:0]   div_t     [2];
	logic                div_ge    [2];
	logic [R_W-1:0]      r_shift;
	logic                r_ge;

	// A period of zero runs as one; every 8-bit period is within the maximum.
	assign p_eff      = (period_q == '0) ? PERIOD_W'(1) : period_q;
	assign p_chg      = CHG_W'(p_eff);
	assign accumulate = changes_q < p_chg;
	assign seed       = changes_q == p_chg;

	assign status.has_change = chg_q;
	assign status.accumulate = accumulate;
	assign status.loss_zero  = (avg_q[LANE_LOSS] == '0);

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			x_w[l] = {diff_q[l], {FRAC_BITS{1'b0}}};
			if (seed) begin
				setup_num[l] = DIV_W'({avg_q[l] + AVG_W'(diff_q[l]), {FRAC_BITS{1'b0}}});
				setup_sub[l] = 1'b0;
			end else if (x_w[l] >= avg_q[l]) begin
				setup_num[l] = DIV_W'(x_w[l] - avg_q[l]);
				setup_sub[l] = 1'b0;
			end else begin
				// Rounds the decrement up so the average itself rounds down.
				setup_num[l] = DIV_W'(avg_q[l] - x_w[l]) + DIV_W'(p_eff - PERIOD_W'(1));
				setup_sub[l] = 1'b1;
			end
			div_t[l]  = {rem_q[l], num_q[l][DIV_W-1]};
			div_ge[l] = div_t[l] >= {1'b0, p_eff};
		end
	end

	assign r_shift = {r_q[R_W-2:0], 1'b0}
		+ (RSI_FULL[cmd.ratio_bit] ? R_W'(avg_q[LANE_GAIN]) : R_W'(0));
	assign r_ge    = r_q >= R_W'(sum_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q      <= PERIOD_RESET;
			last_close_q  <= '0;
			close_valid_q <= 1'b0;
			changes_q     <= '0;
			avg_q[0]      <= '0;
			avg_q[1]      <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if (cfg_write) begin
				period_q      <= cfg_period;
				close_valid_q <= 1'b0;
				changes_q     <= '0;
				avg_q[0]      <= '0;
				avg_q[1]      <= '0;
			end

			if (cmd.load && new_series) begin
				close_valid_q <= 1'b0;
				changes_q     <= '0;
				avg_q[0]      <= '0;
				avg_q[1]      <= '0;
			end

			if (cmd.diff) begin
				if (close_valid_q && changes_q != CHG_SAT) changes_q <= changes_q + CHG_W'(1);
				last_close_q  <= price_q;
				close_valid_q <= 1'b1;
			end

			if (cmd.setup && chg_q && accumulate) begin
				for (int l = 0; l < 2; l++) avg_q[l] <= avg_q[l] + AVG_W'(diff_q[l]);
			end

			if (cmd.update) begin
				for (int l = 0; l < 2; l++) begin
					if (seed_q) avg_q[l] <= num_q[l][AVG_W-1:0];
					else if (sub_q[l]) avg_q[l] <= avg_q[l] - num_q[l][AVG_W-1:0];
					else avg_q[l] <= avg_q[l] + num_q[l][AVG_W-1:0];
				end
			end

			if (cmd.out_load) res_valid_q <= val_q;
		end
	end

	// Working registers carry no reset; each item loads them before use.
	always_ff @(posedge clk) begin
		if (cmd.load) price_q <= close_price;

		if (cmd.diff) begin
			chg_q <= close_valid_q;
			if (price_q > last_close_q) begin
				diff_q[LANE_GAIN] <= price_q - last_close_q;
				diff_q[LANE_LOSS] <= '0;
			end else begin
				diff_q[LANE_GAIN] <= '0;
				diff_q[LANE_LOSS] <= last_close_q - price_q;
			end
		end

		if (cmd.setup) begin
			val_q  <= chg_q && !accumulate;
			seed_q <= seed;
			rsi_q  <= '0;
			for (int l = 0; l < 2; l++) begin
				num_q[l] <= setup_num[l];
				sub_q[l] <= setup_sub[l];
				rem_q[l] <= '0;
			end
		end

		// Restoring division by the period, one quotient bit per cycle.
		if (cmd.div_step) begin
			for (int l = 0; l < 2; l++) begin
				num_q[l] <= {num_q[l][DIV_W-2:0], div_ge[l]};
				rem_q[l] <= div_ge[l] ? PERIOD_W'(div_t[l] - {1'b0, p_eff})
				                      : PERIOD_W'(div_t[l]);
			end
		end

		if (cmd.ratio_init) begin
			sum_q <= S_W'(avg_q[LANE_GAIN]) + S_W'(avg_q[LANE_LOSS]);
			r_q   <= '0;
			rsi_q <= status.loss_zero ? RSI_FULL : RSI_W'(0);
		end

		if (cmd.ratio_shift) begin
			r_q   <= r_shift;
			rsi_q <= {rsi_q[RSI_W-2:0], 1'b0};
		end

		if (cmd.ratio_sub && r_ge) begin
			r_q   <= r_q - R_W'(sum_q);
			rsi_q <= rsi_q + RSI_W'(1);
		end

		if (cmd.out_load) res_value_q <= val_q ? rsi_q : RSI_W'(0);
	end

	assign rsi_valid = res_valid_q;
	assign rsi_value = res_value_q;

endmodule
`default_nettype wire

FILE: rtl/wilder_relative_strength_index_core.sv
`default_nettype none
// An item that only stores a price or adds to the seed sums skips the division and ratio
// steps; an item that yields an RSI runs the division steps and then the ratio steps,
// and the ratio steps are skipped when the loss average is zero.
// Flow: one price at a time; the next price is taken the cycle after the result
// is registered.
// Reset: asynchronous, active low; period returns to 14 and the series history is cleared.
// ----------------------------------------------------------------------------
// wilder_relative_strength_index_core: Wilder RSI over a stream of closes
// Sums gains and losses over the first period changes, seeds the averages,
// then applies Wilder smoothing and reports 100*G/(G+L) in Q7.16.
// ----------------------------------------------------------------------------
module wilder_relative_strength_index_core (
	input  wire logic    clk,
	input  wire logic    arst_n,
	wrsi_price_if.sink   prices,
	wrsi_result_if.source results,
	wrsi_cfg_if.sink     cfg
);
	import wrsi_pkg::*;

	wrsi_cmd_t    cmd;
	wrsi_status_t status;
	logic         cfg_write;

	// The period register is always writable. Writes are expected only while
	// the core is idle; a write clears the series history, so the next price
	// starts a new series.
	assign cfg.ready = 1'b1;
	assign cfg_write = cfg.valid && cfg.ready;

	// The controller walks each accepted price through the difference,
	// setup, division, update and ratio phases, and holds the output
	// transaction in its register until the sink takes it. A new price is
	// accepted while an earlier result still waits on the output.
	wrsi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prices.valid),
		.in_ready  (prices.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath keeps the series state (previous close, change count,
	// gain and loss averages) and runs both averages through their divisions
	// by the period side by side, then forms the ratio bit-serially.
	wrsi_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_write   (cfg_write),
		.cfg_period  (cfg.period),
		.close_price (prices.close_price),
		.new_series  (prices.new_series),
		.rsi_valid   (results.rsi_valid),
		.rsi_value   (results.rsi_value)
	);

endmodule
`default_nettype wire

FILE: rtl/wrsi_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wrsi_checker: port-level checks of the Wilder RSI core
// Watches the price and result channels and the result payload range.
// ----------------------------------------------------------------------------
module wrsi_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic                        out_rsi_valid,
	input wire logic [wrsi_pkg::RSI_W-1:0]  out_rsi_value
);
	import wrsi_pkg::*;

	// A result transaction stays offered until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before it was taken");

	// A valid RSI never exceeds one hundred.
	a_rsi_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_rsi_valid |-> out_rsi_value <= RSI_FULL)
		else $error("RSI above one hundred");

	// Results before the seed carry a zero value.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_rsi_valid |-> out_rsi_value == '0)
		else $error("invalid result with nonzero value");

	// The core works on one price at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second price accepted while one is in progress");

endmodule

bind wilder_relative_strength_index_core wrsi_checker u_wrsi_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (prices.valid),
	.in_ready      (prices.ready),
	.out_valid     (results.valid),
	.out_ready     (results.ready),
	.out_rsi_valid (results.rsi_valid),
	.out_rsi_value (results.rsi_value)
);
`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Wilder RSI core
// Feeds closing-price series through the price channel under several period
// settings and checks every result, field by field, against an in-bench model.
// ----------------------------------------------------------------------------
module tb_top;
	import wrsi_pkg::*;

	// Generous bound on the whole run, in clock cycles. The slowest correct run
	// is about 2300 transactions, each costing the block work plus the longest
	// sender gap plus the longest result stall; this allows several times that.
	localparam int CYCLE_LIMIT = 5_000_000;
	// Cycles to wait after the last expected result before ending the run.
	localparam int TAIL_CYCLES = 150;
	localparam int RANDOM_ITEMS = 1850;

	// One expected result of the core.
	typedef struct packed {
		logic             rsi_valid;
		logic [RSI_W-1:0] rsi_value;
	} rsi_result_t;

	// The scoreboard owns an independent model of the core: it follows every
	// accepted price and period write and queues the result each price causes.
	class rsi_scoreboard;
		logic [PERIOD_W-1:0] period;
		logic [PRICE_W-1:0]  last_close;
		bit                  close_seen;
		int unsigned         changes_seen;
		logic [63:0]         gain_avg;
		logic [63:0]         loss_avg;
		rsi_result_t         rsi_due[$];
		int                  faults;

		function new();
			period = PERIOD_RESET;
			faults = 0;
			clear_series();
		endfunction

		function void clear_series();
			last_close = '0;
			close_seen = 0;
			changes_seen = 0;
			gain_avg = '0;
			loss_avg = '0;
		endfunction

		function void write_period(logic [PERIOD_W-1:0] value);
			period = value;
			clear_series();
		endfunction

		// Wilder smoothing floor((avg*(p-1) + x)/p), split so that it stays in 64 bits.
		function logic [63:0] smooth(logic [63:0] avg, logic [63:0] x, int unsigned p);
			if (x >= avg)
				return avg + (x - avg) / p;
			return avg - ((avg - x) + (p - 1)) / p;
		endfunction

		// floor(100 * 2^FRAC_BITS * g / (g + l)); the product needs more than 64 bits.
		function logic [RSI_W-1:0] rsi_of(logic [63:0] g, logic [63:0] l);
			logic [127:0] scaled;
			logic [127:0] quotient;
			if (l == 0)
				return RSI_FULL;
			scaled = 128'(g) * 128'(RSI_FULL);
			quotient = scaled / 128'(g + l);
			return quotient[RSI_W-1:0];
		endfunction

		function void note_price(logic [PRICE_W-1:0] price, logic restart);
			int unsigned p;
			logic [63:0] gain;
			logic [63:0] loss;
			rsi_result_t due;
			p = (period == 0) ? 1 : period;
			gain = '0;
			loss = '0;
			due = '0;
			if (restart)
				clear_series();
			if (close_seen) begin
				if (price > last_close)
					gain = 64'(price - last_close);
				else
					loss = 64'(last_close - price);
				if (changes_seen < PERIOD_MAX + 1)
					changes_seen++;
				if (changes_seen < p) begin
					// Still collecting the raw sums that seed the averages.
					gain_avg += gain;
					loss_avg += loss;
				end else if (changes_seen == p) begin
					gain_avg = ((gain_avg + gain) << FRAC_BITS) / p;
					loss_avg = ((loss_avg + loss) << FRAC_BITS) / p;
					due.rsi_valid = 1'b1;
				end else begin
					gain_avg = smooth(gain_avg, gain << FRAC_BITS, p);
					loss_avg = smooth(loss_avg, loss << FRAC_BITS, p);
					due.rsi_valid = 1'b1;
				end
				if (due.rsi_valid)
					due.rsi_value = rsi_of(gain_avg, loss_avg);
			end
			last_close = price;
			close_seen = 1;
			rsi_due = {rsi_due, due};
		endfunction

		function void report(string msg);
			if (faults < 10)
				$display("%0t: %s", $time, msg);
			faults++;
		endfunction

		function void check_result(logic rsi_valid, logic [RSI_W-1:0] rsi_value);
			rsi_result_t due;
			if (rsi_due.size() == 0) begin
				report($sformatf("result with nothing expected: rsi_valid=%0b rsi_value=%0d",
					rsi_valid, rsi_value));
				return;
			end
			due = rsi_due.pop_front();
			if (rsi_valid !== due.rsi_valid)
				report($sformatf("rsi_valid mismatch: expected %0b, got %0b",
					due.rsi_valid, rsi_valid));
			if (rsi_value !== due.rsi_value)
				report($sformatf("rsi_value mismatch: expected %0d, got %0d",
					due.rsi_value, rsi_value));
		endfunction

		function int pending();
			return rsi_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycles;

	wrsi_price_if  prices_ch();
	wrsi_result_if results_ch();
	wrsi_cfg_if    cfg_ch();

	rsi_scoreboard sb = new();

	wilder_relative_strength_index_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.prices  (prices_ch.sink),
		.results (results_ch.source),
		.cfg     (cfg_ch.sink)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Idle length shared by both sides: mostly none or short, rarely long.
	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return 0;
		if (pick < 88)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 150);
	endfunction

	// Next close of a random walk. Most steps are small so that the averages
	// settle into a realistic range; a share of them are the price extremes,
	// unchanged prices or plain noise. A trend of 1 only rises, 2 only falls.
	function automatic logic [PRICE_W-1:0] next_close(logic [PRICE_W-1:0] prev, int trend);
		int pick;
		int w;
		logic [32:0] span;
		logic [PRICE_W-1:0] delta;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			return '0;
		if (pick < 6)
			return '1;
		if (pick < 12)
			return prev;
		if (pick < 17)
			return $urandom;
		w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32) : $urandom_range(0, 12);
		span = (33'd1 << w) - 33'd1;
		delta = $urandom & span[PRICE_W-1:0];
		if (trend == 1 || (trend == 0 && $urandom_range(0, 1) == 1))
			return prev + delta;
		return prev - delta;
	endfunction

	// Offers one price and returns at the edge where it was accepted. The caller
	// is at a rising edge; valid is only dropped when a gap is inserted, so a
	// back-to-back transaction never lowers and raises valid in the same step.
	task automatic put_close(logic [PRICE_W-1:0] price, logic restart, int gap);
		if (gap > 0) begin
			prices_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		prices_ch.valid <= 1'b1;
		prices_ch.close_price <= price;
		prices_ch.new_series <= restart;
		do @(posedge clk); while (!prices_ch.ready);
	endtask

	// Holds the sender until every queued result has been delivered. The first
	// edge lets the monitor note a price accepted at the caller's edge.
	task automatic drain();
		prices_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Period writes are only issued once the core has gone quiet.
	task automatic set_period(logic [PERIOD_W-1:0] value);
		drain();
		repeat (4) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.period <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// Cycle counter and watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Monitors sample the channels at the rising edge, before the core's own
	// updates of that edge take effect, so each transaction is seen exactly once.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				sb.write_period(cfg_ch.period);
			if (prices_ch.valid && prices_ch.ready)
				sb.note_price(prices_ch.close_price, prices_ch.new_series);
			if (results_ch.valid && results_ch.ready)
				sb.check_result(results_ch.rsi_valid, results_ch.rsi_value);
		end
	end

	// Result side back-pressure: runs of ready, sometimes very long ones, broken
	// by stalls drawn from the same mostly-short distribution as the sender.
	initial begin
		int run;
		int stall;
		results_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 8);
			results_ch.ready <= 1'b1;
			repeat (run) @(posedge clk);
			stall = idle_len();
			if (stall > 0) begin
				results_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Main stimulus.
	initial begin
		logic [PRICE_W-1:0] series_a [16];
		logic [PRICE_W-1:0] price;
		logic [PERIOD_W-1:0] next_period;
		int sent;
		int phase;
		int span_len;
		int trend;
		int hold_at;
		bit steady;

		cycles = 0;
		arst_n = 1'b0;
		prices_ch.valid <= 1'b0;
		prices_ch.close_price <= '0;
		prices_ch.new_series <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.period <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed series under the reset period of 14: full-scale rise, an
		// unchanged price, full-scale fall, then enough ordinary changes to reach
		// the seed (15th price) and one smoothing step (16th price).
		series_a = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
			32'd1000, 32'd900, 32'd1500, 32'd1500, 32'd2, 32'd70000, 32'd65000,
			32'h8000_0000, 32'h7FFF_FFFF, 32'd12, 32'd13, 32'd11};
		foreach (series_a[i]) begin
			put_close(series_a[i], 1'b0, (i % 3 == 1) ? 2 : 0);
			// Hold the sender mid-series until the core has answered everything.
			if (i == 7)
				drain();
		end

		// A period of zero behaves as one: every change yields a result at once.
		// Covers an unchanged price with no losses (exactly 100), a pure gain,
		// a pure loss, a restart mid-series and a full-scale step after it.
		set_period('0);
		put_close(32'd5, 1'b0, 0);
		put_close(32'd5, 1'b0, 0);
		put_close(32'd9, 1'b0, 1);
		put_close(32'd0, 1'b0, 0);
		put_close(32'd77, 1'b1, 0);
		put_close(32'hFFFF_FFFF, 1'b0, 0);

		// Random phases. The first two pin the period extremes; later ones favor
		// short periods so that most prices produce a result, with occasional
		// zero and long periods. Each phase is mostly a well-formed series with a
		// random walk of prices; restarts and noise prices are mixed in.
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			case (phase)
				0: next_period = 8'd255;
				1: next_period = 8'd1;
				default: begin
					case ($urandom_range(0, 9))
						0: next_period = 8'd0;
						1: next_period = 8'd1;
						2: next_period = PERIOD_W'($urandom_range(1, 255));
						default: next_period = PERIOD_W'($urandom_range(2, 20));
					endcase
				end
			endcase
			set_period(next_period);

			span_len = int'(next_period) + int'($urandom_range(10, 100));
			case ($urandom_range(0, 9))
				0, 1: trend = 1;
				2, 3: trend = 2;
				default: trend = 0;
			endcase
			steady = ($urandom_range(0, 3) == 0);
			hold_at = ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, span_len)) : -1;
			price = $urandom;

			for (int k = 0; k < span_len; k++) begin
				price = next_close(price, trend);
				put_close(price, ($urandom_range(0, 99) < 3), steady ? 0 : idle_len());
				if (k == hold_at)
					drain();
				sent++;
			end
			phase++;
		end

		// All stimulus is in; let the last results come out, then watch for strays.
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.faults == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
